// File: design/sfdc_pkg.sv
// sfdc_pkg: shared constants and types for the serial frame deframer/classifier.
// Depends on nothing; imported by sfdc_ram users, sfdc_drain and the top level.
package sfdc_pkg;

  localparam int BUF_BYTES = 256;
  localparam int BUF_AW    = $clog2(BUF_BYTES);
  localparam int FILL_W    = $clog2(BUF_BYTES + 1);
  localparam int LEN_W     = 18;
  localparam int LANE_W    = 4;

  localparam logic [7:0] HDR0       = 8'h4F;
  localparam logic [7:0] HDR1       = 8'h4B;
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] KIND_UID   = 8'h1E;
  localparam logic [7:0] KIND_ERR   = 8'h1F;
  localparam logic [7:0] KIND_PARAM = 8'h20;

  localparam int LEN_LIMIT = 128;
  localparam int UID_LEN   = 17;
  localparam int ERR_LEN   = 18;
  localparam int HDR_BYTES = 4;

  localparam logic [2:0] CLS_TEXT  = 3'd0;
  localparam logic [2:0] CLS_UID   = 3'd1;
  localparam logic [2:0] CLS_ERR   = 3'd2;
  localparam logic [2:0] CLS_PARAM = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] len;
    logic [2:0]        cls;
  } drn_cmd_t;

endpackage

// File: design/sfdc_ram.sv
// sfdc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/sfdc_drain.sv
// sfdc_drain: reads a closed message out of the buffer RAM and packs it into
// 8-byte words held in an output register. Depends on sfdc_pkg.
module sfdc_drain (
  input  logic                     clk,
  input  logic                     rst,
  input  sfdc_pkg::drn_cmd_t       cmd,
  output logic                     busy,
  output logic                     rd_en,
  output logic [sfdc_pkg::BUF_AW-1:0] rd_addr,
  input  logic [7:0]               rd_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [63:0]              data_word,
  output logic [3:0]               byte_count,
  output logic                     last_word,
  output logic [2:0]               message_class
);
  import sfdc_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_RD   = 4'b0010,
    D_CAP  = 4'b0100,
    D_PUSH = 4'b1000
  } dstate_t;

  dstate_t           state, state_next;
  logic [FILL_W-1:0] rd_ptr;
  logic [FILL_W-1:0] msg_len;
  logic [2:0]        cls;
  logic [LANE_W-1:0] lane;
  logic [63:0]       word_buf;
  logic [FILL_W-1:0] ptr_inc;
  logic [LANE_W-1:0] lane_inc;
  logic              word_end;
  logic              out_free;

  assign ptr_inc  = rd_ptr + FILL_W'(1);
  assign lane_inc = lane + LANE_W'(1);
  assign word_end = (lane_inc == LANE_W'(8)) || (ptr_inc == msg_len);
  assign out_free = !out_valid || out_ready;
  assign busy     = (state != D_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_ptr[BUF_AW-1:0];
    case (state)
      D_RD: begin
        rd_en = 1'b1;
      end
      D_CAP: begin
        rd_en   = !word_end;
        rd_addr = ptr_inc[BUF_AW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE: if (cmd.start) state_next = D_RD;
      D_RD:   state_next = D_CAP;
      D_CAP:  if (word_end) state_next = D_PUSH;
      D_PUSH: begin
        if (out_free) state_next = (rd_ptr == msg_len) ? D_IDLE : D_RD;
      end
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= D_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == D_PUSH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        if (cmd.start) begin
          rd_ptr   <= '0;
          msg_len  <= cmd.len;
          cls      <= cmd.cls;
          lane     <= '0;
          word_buf <= '0;
        end
      end
      D_CAP: begin
        word_buf[lane[2:0]*8 +: 8] <= rd_data;
        rd_ptr <= ptr_inc;
        lane   <= lane_inc;
      end
      D_PUSH: begin
        if (out_free) begin
          data_word     <= word_buf;
          byte_count    <= lane;
          last_word     <= (rd_ptr == msg_len);
          message_class <= cls;
          word_buf      <= '0;
          lane          <= '0;
        end
      end
      default: begin
        lane <= lane;
      end
    endcase
  end

endmodule

// File: design/serial_frame_deframer_classifier.sv
// serial_frame_deframer_classifier: top level; byte collector, framing and
// classification control around the buffer RAM and the word drain unit.
// A byte that closes nothing is accepted (S_IDLE), then evaluated (S_EVAL); a
// repeated header then rewrites the buffer head in S_RST0 and S_RST1. A
// closing byte drains the buffered bytes with one RAM read per byte; bytes
// are taken again once the last word sits in the output register. Reset
// clears control, fill count, current and previous byte; the buffer RAM
// is not cleared, entries are read only below the fill count.
module serial_frame_deframer_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] data_word,
  output logic [3:0]  byte_count,
  output logic        last_word,
  output logic [2:0]  message_class
);
  import sfdc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_RST0 = 5'b00100,
    S_RST1 = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  localparam logic signed [LEN_W-1:0] LEN_LIMIT_S = LEN_W'(LEN_LIMIT);

  state_t            state, state_next;
  logic [FILL_W-1:0] fill;
  logic [7:0]        cur_byte;
  logic [7:0]        prev_byte;
  logic [7:0]        hdr [5];
  logic              accept;
  drn_cmd_t          cmd;
  logic              drn_busy;
  logic              we;
  logic [BUF_AW-1:0] waddr;
  logic [7:0]        wdata;
  logic              rd_en;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  logic signed [LEN_W-1:0] len_v;
  logic signed [LEN_W-1:0] need;
  logic signed [LEN_W-1:0] fill_s;
  logic              has_hdr;
  logic              is_bin;
  logic              do_emit;
  logic              do_drop;
  logic              do_restart;
  logic [2:0]        cls;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign len_v  = $signed({{(LEN_W-16){hdr[2][7]}}, hdr[2], 8'h00})
                + $signed({{(LEN_W-8){hdr[3][7]}}, hdr[3]});
  assign need   = len_v + LEN_W'(HDR_BYTES);
  assign fill_s = $signed({{(LEN_W-FILL_W){1'b0}}, fill});

  assign has_hdr = (fill >= FILL_W'(2)) && (hdr[0] == HDR0) && (hdr[1] == HDR1);
  assign is_bin  = (fill >= FILL_W'(4)) && has_hdr && (len_v < LEN_LIMIT_S);

  always_comb begin
    do_emit    = 1'b0;
    do_drop    = 1'b0;
    do_restart = 1'b0;
    if (is_bin) begin
      if (need == fill_s) begin
        do_emit = 1'b1;
      end else if (need < fill_s) begin
        do_drop = 1'b1;
      end else if (prev_byte == HDR0 && cur_byte == HDR1) begin
        do_restart = 1'b1;
      end
    end else if (cur_byte == NEWLINE || fill >= FILL_W'(BUF_BYTES)) begin
      do_emit = 1'b1;
    end
  end

  always_comb begin
    if (!has_hdr) begin
      cls = CLS_TEXT;
    end else if (fill < FILL_W'(5)) begin
      cls = CLS_OTHER;
    end else if (len_v == LEN_W'(UID_LEN) && fill == FILL_W'(UID_LEN + HDR_BYTES)
                 && hdr[4] == KIND_UID) begin
      cls = CLS_UID;
    end else if (len_v == LEN_W'(ERR_LEN) && fill == FILL_W'(ERR_LEN + HDR_BYTES)
                 && hdr[4] == KIND_ERR) begin
      cls = CLS_ERR;
    end else if (hdr[4] == KIND_PARAM) begin
      cls = CLS_PARAM;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign cmd.start = (state == S_EVAL) && do_emit;
  assign cmd.len   = fill;
  assign cmd.cls   = cls;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_EVAL;
      S_EVAL: begin
        if (do_emit) begin
          state_next = S_WAIT;
        end else if (do_restart) begin
          state_next = S_RST0;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RST0: state_next = S_RST1;
      S_RST1: state_next = S_IDLE;
      S_WAIT: if (!drn_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = fill[BUF_AW-1:0];
    wdata = rx_byte;
    case (state)
      S_IDLE: we = accept && (fill < FILL_W'(BUF_BYTES));
      S_RST0: begin
        we    = 1'b1;
        waddr = BUF_AW'(0);
        wdata = HDR0;
      end
      S_RST1: begin
        we    = 1'b1;
        waddr = BUF_AW'(1);
        wdata = HDR1;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cur_byte  <= '0;
      prev_byte <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            prev_byte <= cur_byte;
            cur_byte  <= rx_byte;
            if (fill < FILL_W'(BUF_BYTES)) fill <= fill + FILL_W'(1);
          end
        end
        S_EVAL: begin
          if (do_emit || do_drop) begin
            fill <= '0;
          end else if (do_restart) begin
            fill <= FILL_W'(2);
          end
        end
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 5; k++) begin
      if (accept && fill == FILL_W'(k)) hdr[k] <= rx_byte;
    end
    if (state == S_EVAL && do_restart) begin
      hdr[0] <= HDR0;
      hdr[1] <= HDR1;
    end
  end

  sfdc_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_buf (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  sfdc_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .busy         (drn_busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last_word    (last_word),
    .message_class(message_class)
  );

  a_no_write_while_drain: assert property (@(posedge clk) disable iff (rst)
    drn_busy |-> !we)
    else $error("buffer written while a message drains");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(BUF_BYTES))
    else $error("fill count past buffer size");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 4'd0 && byte_count <= 4'd8))
    else $error("word byte count out of range");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> message_class <= CLS_OTHER)
    else $error("bad message class");

  a_emit_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (fill == '0 && drn_busy))
    else $error("emit did not empty buffer or start drain");

endmodule
